/* sv/b32d_pkg.sv */
// Shared types, codes and character tables for the Base32 stream decoder.
`default_nettype none
package b32d_pkg;

  // Result kinds carried on the master-side tuser.
  localparam logic [1:0] KIND_BYTE    = 2'd0;
  localparam logic [1:0] KIND_OK      = 2'd1;
  localparam logic [1:0] KIND_INVALID = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_ALPHABET_HEX = 2'd0;
  localparam logic [1:0] REG_DROP_GARBAGE = 2'd1;

  // Byte-order mark bytes.
  localparam logic [7:0] BOM_0 = 8'hEF;
  localparam logic [7:0] BOM_1 = 8'hBB;
  localparam logic [7:0] BOM_2 = 8'hBF;

  // Characters of interest.
  localparam logic [7:0] CH_PAD   = 8'h3D;  // '='
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_2     = 8'h32;
  localparam logic [7:0] CH_7     = 8'h37;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UV    = 8'h56;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LV    = 8'h76;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] OFS_DIGITS = 8'd26;  // '2'..'7' start here in the standard set
  localparam logic [7:0] OFS_LETTERS = 8'd10; // 'A'..'V' start here in the hex set

  localparam logic [3:0] PAD_NONE = 4'd8;

  typedef struct packed {
    logic       is_pad;
    logic       bad;
    logic [4:0] val;
  } sym_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

  function automatic sym_t sym_decode(input logic [7:0] c, input logic hex);
    sym_t       s;
    logic [7:0] d;
    s = '{is_pad: 1'b0, bad: 1'b0, val: 5'd0};
    d = 8'd0;
    if (c == CH_PAD) begin
      s.is_pad = 1'b1;
    end else if (hex) begin
      if (c >= CH_0 && c <= CH_9) d = c - CH_0;
      else if (c >= CH_UA && c <= CH_UV) d = c - CH_UA + OFS_LETTERS;
      else if (c >= CH_LA && c <= CH_LV) d = c - CH_LA + OFS_LETTERS;
      else s.bad = 1'b1;
    end else begin
      if (c >= CH_UA && c <= CH_UZ) d = c - CH_UA;
      else if (c >= CH_LA && c <= CH_LZ) d = c - CH_LA;
      else if (c >= CH_2 && c <= CH_7) d = c - CH_2 + OFS_DIGITS;
      else s.bad = 1'b1;
    end
    s.val = d[4:0];
    return s;
  endfunction

  // Bytes out of a group whose padding starts at pos; zero flags bad padding.
  function automatic logic [2:0] group_len(input logic [3:0] pos);
    logic [2:0] n;
    case (pos)
      4'd2:    n = 3'd1;
      4'd4:    n = 3'd2;
      4'd5:    n = 3'd3;
      4'd7:    n = 3'd4;
      4'd8:    n = 3'd5;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

endpackage
`default_nettype wire

/* sv/base32_stream_decoder_core.sv */
// Base32 stream decoder: characters in, decoded bytes and end-of-stream status out.
`default_nettype none
// Usage
//   Slave side (s_*) takes one word per character: tdata is the character byte,
//   tuser[0] set marks end of stream (tdata then ignored). A word is taken when
//   s_tvalid and s_tready are both high.
//   Master side (m_*) gives decoded bytes (tuser = 0) and, for each end of
//   stream, one status word (tuser = 1 ok, 2 invalid input); tlast flags the
//   final result caused by one input word.
//   Configuration (cfg_*) writes alphabet_hex (index 0) and drop_garbage
//   (index 1); write only while the block is idle. cfg_ready is always high.
// Latency and throughput
//   A word is decoded in the cycle it is taken; its results appear on the
//   master side from the next cycle on, one per cycle while m_tready is high.
//   Characters that give no result are taken every cycle while no result
//   waits. A word that completes a group loads up to five results into the
//   output buffer; the next word is taken once the buffer is empty or its
//   last result leaves.
// Reset and stalls
//   rst clears decoder state, registers and the output buffer. A stalled
//   master side holds the current result; the slave side stalls while a
//   result other than the last one waits, and while the last one is held.
module base32_stream_decoder_core (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] in_char
  input  wire logic [0:0] s_tuser,   // [0] op
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // [7:0] out_byte
  output logic [1:0]      m_tuser,   // [1:0] kind
  output logic            m_tlast,   // run_last
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [0:0] cfg_data
);
  import b32d_pkg::*;

  // Registers and stream state.
  logic       alphabet_hex, drop_garbage;
  logic [2:0] symbol_count, symbol_count_next;
  logic [3:0] pad_position, pad_position_next;
  logic       pad_seen, pad_seen_next;
  logic       stream_finished, stream_finished_next;
  logic       error_seen, error_seen_next;
  logic [1:0] mark_phase, mark_phase_next;
  logic [4:0] symbol_store [8];

  // Output buffer.
  logic [39:0] obuf;
  logic [2:0]  bytes_left;
  logic        status_pending;
  logic [1:0]  status_kind;

  // Decode control.
  logic        accept;
  logic        wr_en;
  logic [4:0]  wr_val;
  logic [3:0]  dec_pos;
  logic        load;
  logic [2:0]  load_bytes;
  logic        load_status;
  logic [1:0]  load_kind;
  logic        take;
  logic        err_v;
  logic [2:0]  len;
  logic [39:0] acc;
  sym_t        sym;

  assign cfg_ready = 1'b1;
  assign m_tvalid  = (bytes_left != 3'd0) || status_pending;
  assign m_tdata   = (bytes_left != 3'd0) ? obuf[39:32] : 8'd0;
  assign m_tuser   = (bytes_left != 3'd0) ? KIND_BYTE : status_kind;
  assign m_tlast   = (bytes_left != 3'd0) ? ((bytes_left == 3'd1) && !status_pending) : 1'b1;
  assign s_tready  = !m_tvalid || (m_tready && m_tlast);
  assign accept    = s_tvalid && s_tready;
  assign sym       = sym_decode(s_tdata, alphabet_hex);

  always_comb begin
    symbol_count_next    = symbol_count;
    pad_position_next    = pad_position;
    pad_seen_next        = pad_seen;
    stream_finished_next = stream_finished;
    error_seen_next      = error_seen;
    mark_phase_next      = mark_phase;
    wr_en       = 1'b0;
    wr_val      = 5'd0;
    dec_pos     = pad_position;
    load        = 1'b0;
    load_bytes  = 3'd0;
    load_status = 1'b0;
    load_kind   = KIND_OK;
    take        = 1'b0;
    err_v       = error_seen;
    len         = 3'd0;
    if (s_tuser[0]) begin
      // End of stream: flush a partial group, report, and start over.
      load        = 1'b1;
      load_status = 1'b1;
      if (!error_seen && !stream_finished) begin
        if (mark_phase == 2'd1 || mark_phase == 2'd2) err_v = !drop_garbage;
        if (!err_v && symbol_count != 3'd0) begin
          dec_pos = pad_seen ? pad_position : {1'b0, symbol_count};
          len     = group_len(dec_pos);
          if (len == 3'd0) err_v = 1'b1;
          else load_bytes = len;
        end
      end
      load_kind            = err_v ? KIND_INVALID : KIND_OK;
      symbol_count_next    = 3'd0;
      pad_position_next    = PAD_NONE;
      pad_seen_next        = 1'b0;
      stream_finished_next = 1'b0;
      error_seen_next      = 1'b0;
      mark_phase_next      = 2'd0;
    end else if (!error_seen && !stream_finished) begin
      // Byte-order mark tracking; a broken mark counts as garbage.
      case (mark_phase)
        2'd0: begin
          if (s_tdata == BOM_0) begin
            mark_phase_next = 2'd1;
          end else begin
            mark_phase_next = 2'd3;
            take = 1'b1;
          end
        end
        2'd1: begin
          if (s_tdata == BOM_1) begin
            mark_phase_next = 2'd2;
          end else begin
            mark_phase_next = 2'd3;
            error_seen_next = !drop_garbage;
            take = drop_garbage;
          end
        end
        2'd2: begin
          mark_phase_next = 2'd3;
          if (s_tdata != BOM_2) begin
            error_seen_next = !drop_garbage;
            take = drop_garbage;
          end
        end
        default: take = 1'b1;
      endcase
      if (take && !is_space(s_tdata)) begin
        if (sym.bad) begin
          error_seen_next = !drop_garbage;
        end else if (!sym.is_pad && pad_seen) begin
          error_seen_next = 1'b1;
        end else begin
          wr_en  = 1'b1;
          wr_val = sym.is_pad ? 5'd0 : sym.val;
          if (sym.is_pad && !pad_seen) begin
            pad_seen_next     = 1'b1;
            pad_position_next = {1'b0, symbol_count};
          end
          symbol_count_next = symbol_count + 3'd1;
          if (symbol_count == 3'd7) begin
            // Group complete: decode it with the symbol just taken.
            dec_pos = pad_position_next;
            if (pad_seen_next) stream_finished_next = 1'b1;
            len = group_len(dec_pos);
            if (len == 3'd0) begin
              error_seen_next = 1'b1;
            end else begin
              load       = 1'b1;
              load_bytes = len;
            end
          end
        end
      end
    end
  end

  // Assemble the 40-bit group, the symbol being written overriding its slot.
  always_comb begin
    acc = 40'd0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < dec_pos) begin
        if (wr_en && symbol_count == 3'(i)) acc[39 - 5*i -: 5] = wr_val;
        else acc[39 - 5*i -: 5] = symbol_store[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alphabet_hex    <= 1'b0;
      drop_garbage    <= 1'b0;
      symbol_count    <= 3'd0;
      pad_position    <= PAD_NONE;
      pad_seen        <= 1'b0;
      stream_finished <= 1'b0;
      error_seen      <= 1'b0;
      mark_phase      <= 2'd0;
      bytes_left      <= 3'd0;
      status_pending  <= 1'b0;
      status_kind     <= KIND_OK;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ALPHABET_HEX: alphabet_hex <= cfg_data[0];
          REG_DROP_GARBAGE: drop_garbage <= cfg_data[0];
          default: ;
        endcase
      end
      if (accept) begin
        symbol_count    <= symbol_count_next;
        pad_position    <= pad_position_next;
        pad_seen        <= pad_seen_next;
        stream_finished <= stream_finished_next;
        error_seen      <= error_seen_next;
        mark_phase      <= mark_phase_next;
      end
      if (accept && load) begin
        bytes_left     <= load_bytes;
        status_pending <= load_status;
        status_kind    <= load_kind;
      end else if (m_tvalid && m_tready) begin
        // Advance: bytes first, then the status word.
        if (bytes_left != 3'd0) bytes_left <= bytes_left - 3'd1;
        else status_pending <= 1'b0;
      end
    end
  end

  // Payload: symbol slots and the byte shifter.
  always_ff @(posedge clk) begin
    if (accept && wr_en) symbol_store[symbol_count] <= wr_val;
    if (accept && load) obuf <= acc;
    else if (m_tvalid && m_tready && bytes_left != 3'd0) obuf <= {obuf[31:0], 8'd0};
  end

  // Checks.
  a_bytes_range: assert property (@(posedge clk) disable iff (rst)
    bytes_left <= 3'd5) else $error("output byte count out of range");
  a_status_word: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != KIND_BYTE |-> m_tlast && m_tdata == 8'd0)
    else $error("status word malformed");
  a_finish_pad: assert property (@(posedge clk) disable iff (rst)
    stream_finished |-> pad_seen) else $error("finished without padding");
  a_pad_pos: assert property (@(posedge clk) disable iff (rst)
    (pad_seen && pad_position < PAD_NONE) || (!pad_seen && pad_position == PAD_NONE))
    else $error("padding position inconsistent");
  a_eos_clear: assert property (@(posedge clk) disable iff (rst)
    accept && s_tuser[0] |=> symbol_count == 3'd0 && !pad_seen && !error_seen
      && mark_phase == 2'd0 && status_pending)
    else $error("end of stream did not restart the decoder");

endmodule
`default_nettype wire
